FILE: rtl/core/rrga_pkg.sv
// ----------------------------------------------------------------------------
// rrga_pkg - shared types and helpers for the round robin group allocator
// constants, register indexes, sequencer states and small helper functions
// ----------------------------------------------------------------------------
package rrga_pkg;

    // number of processor groups the allocator keeps counts for
    localparam int unsigned MaxGroups    = 4;
    localparam int unsigned GroupIdxW    = 2;
    localparam int unsigned GroupCountW  = 3;
    localparam int unsigned CpuCountW    = 7;
    localparam int unsigned CountW       = 16;
    localparam int unsigned CapW         = 9;
    localparam int unsigned MaskW        = 64;
    localparam int unsigned CfgIndexW    = 3;
    localparam int unsigned CfgDataW     = 7;

    localparam logic [CpuCountW-1:0]   CpusMax   = 7'd64;
    localparam logic [CountW-1:0]      CountMax  = 16'hFFFF;
    localparam logic [GroupCountW-1:0] GroupsMax = 3'(MaxGroups);

    // configuration register indexes
    localparam logic [CfgIndexW-1:0] CfgGroupCount = 3'd0;
    localparam logic [CfgIndexW-1:0] CfgGroup0Cpus = 3'd1;
    localparam logic [CfgIndexW-1:0] CfgGroup1Cpus = 3'd2;
    localparam logic [CfgIndexW-1:0] CfgGroup2Cpus = 3'd3;
    localparam logic [CfgIndexW-1:0] CfgGroup3Cpus = 3'd4;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CAP,
        ST_SCAN,
        ST_UPDATE
    } rrga_state_t;

    // control decoded from the sequencer state
    typedef struct packed {
        logic sel_cap;
        logic cap_add;
        logic scan;
        logic update;
    } rrga_ctrl_t;

    // zero means one group, above the limit saturates
    function automatic logic [GroupCountW-1:0] groups_in_use(
        input logic [GroupCountW-1:0] gc
    );
        logic [GroupCountW-1:0] g;
        g = gc;
        if (g == '0)
            g = 3'd1;
        if (g > GroupsMax)
            g = GroupsMax;
        return g;
    endfunction

    // cpu counts above 64 saturate
    function automatic logic [CpuCountW-1:0] cpus_sat(
        input logic [CpuCountW-1:0] c
    );
        return (c > CpusMax) ? CpusMax : c;
    endfunction

    // n low bits set, n in 0..64
    function automatic logic [MaskW-1:0] mask_for(input logic [CpuCountW-1:0] n);
        return ~({MaskW{1'b1}} << n);
    endfunction

endpackage

FILE: rtl/core/round_robin_group_allocator_unit.sv
// ----------------------------------------------------------------------------
// round_robin_group_allocator_unit - round robin worker placement
// places each worker request into a processor group, skipping full groups
// until the batch is oversubscribed, and returns group and affinity mask
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_stall    start_batch
//  out       output     out_valid / out_stall  group_index, affinity_mask
//  cfg       input      cfg_write              cfg_index, cfg_data
//
//  after the edge that takes an item the sequencer runs ST_CAP over the g
//  groups in use (1..4), then ST_SCAN over s groups (1..g), then ST_UPDATE,
//  which registers the result and raises out_valid; the capacity sum and
//  the scan share one read port on the cpu registers, one group a cycle
//  reset clears counts, batch total, pointer and config to reset values
//  in_stall stays high while an item is in work or a result waits on out
//  a stalled result holds in the output register until taken
//
module round_robin_group_allocator_unit
    import rrga_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // request channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   start_batch,
    // result channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [GroupIdxW-1:0]   group_index,
    output logic [MaskW-1:0]       affinity_mask,
    // configuration
    input  logic                   cfg_write,
    input  logic [CfgIndexW-1:0]   cfg_index,
    input  logic [CfgDataW-1:0]    cfg_data
);

    // configuration registers
    logic [GroupCountW-1:0] group_count_reg;
    logic [CpuCountW-1:0]   group_cpus_reg [MaxGroups];

    // allocation state
    logic [GroupIdxW-1:0]   group_pointer_reg, group_pointer_next;
    logic [CountW-1:0]      assigned_reg [MaxGroups];
    logic [CountW-1:0]      batch_total_reg, batch_total_next;

    // sequencer
    rrga_state_t            state_reg, state_next;
    rrga_ctrl_t             ctrl;
    logic [GroupIdxW-1:0]   idx_reg, idx_next;     // capacity index / scan step
    logic [GroupIdxW-1:0]   p_reg, p_next;         // group under test
    logic [CapW-1:0]        cap_reg, cap_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    logic [GroupIdxW-1:0]   group_index_reg, group_index_next;
    logic [MaskW-1:0]       mask_reg, mask_next;

    logic                   in_fire;
    logic                   out_fire;
    logic [GroupCountW-1:0] g_use;
    logic [GroupIdxW-1:0]   g_last;     // index of the last group in use
    logic [GroupIdxW-1:0]   sel_idx;
    logic [CpuCountW-1:0]   sel_cpus;
    logic [CountW-1:0]      sel_assigned;
    logic                   hit;
    logic [GroupIdxW-1:0]   p_wrap;
    logic                   last_step;
    logic [GroupIdxW-1:0]   start_p;

    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;

    assign out_valid     = out_valid_reg;
    assign group_index   = group_index_reg;
    assign affinity_mask = mask_reg;

    assign g_use  = groups_in_use(group_count_reg);
    assign g_last = GroupIdxW'(g_use - 3'd1);

    // shared read port over the cpu registers: capacity index or scan pointer
    assign sel_idx      = ctrl.sel_cap ? idx_reg : p_reg;
    assign sel_cpus     = cpus_sat(group_cpus_reg[sel_idx]);
    assign sel_assigned = assigned_reg[p_reg];

    // group has room, or the batch is oversubscribed
    assign hit = ({9'd0, sel_assigned} < {16'd0, sel_cpus} + 25'd0)
              || (batch_total_reg >= {7'd0, cap_reg});

    assign p_wrap    = (p_reg == g_last) ? '0 : p_reg + 2'd1;
    assign last_step = (idx_reg == g_last);

    // pointer beyond the groups in use wraps to group zero
    assign start_p = (start_batch || ({1'b0, group_pointer_reg} >= g_use))
                   ? '0 : group_pointer_reg;

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_CAP;
            end
            ST_CAP:
            begin
                if (last_step)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (hit || last_step)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control outputs of the sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl = '0;
            end
            ST_CAP:
            begin
                ctrl.sel_cap = 1'b1;
                ctrl.cap_add = 1'b1;
            end
            ST_SCAN:
            begin
                ctrl.scan = 1'b1;
            end
            ST_UPDATE:
            begin
                ctrl.update = 1'b1;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        idx_next           = idx_reg;
        p_next             = p_reg;
        cap_next           = cap_reg;
        group_pointer_next = group_pointer_reg;
        batch_total_next   = batch_total_reg;
        out_valid_next     = out_valid_reg;
        group_index_next   = group_index_reg;
        mask_next          = mask_reg;

        if (out_fire)
            out_valid_next = 1'b0;

        if (in_fire)
        begin
            idx_next = '0;
            p_next   = start_p;
            cap_next = '0;
            if (start_batch)
            begin
                group_pointer_next = '0;
                batch_total_next   = '0;
            end
        end

        // capacity sum, one group a cycle
        if (ctrl.cap_add)
        begin
            cap_next = cap_reg + {2'd0, sel_cpus};
            idx_next = last_step ? '0 : idx_reg + 2'd1;
        end

        // scan from the pointer; after a full miss p is back at its start
        if (ctrl.scan && !hit)
        begin
            p_next   = p_wrap;
            idx_next = idx_reg + 2'd1;
        end

        // place the worker in group p
        if (ctrl.update)
        begin
            if (batch_total_reg != CountMax)
                batch_total_next = batch_total_reg + 16'd1;
            group_pointer_next = p_wrap;
            out_valid_next     = 1'b1;
            group_index_next   = p_reg;
            mask_next          = mask_for(sel_cpus);
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            group_pointer_reg <= '0;
            batch_total_reg   <= '0;
            out_valid_reg     <= 1'b0;
            idx_reg           <= '0;
            p_reg             <= '0;
            cap_reg           <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            group_pointer_reg <= group_pointer_next;
            batch_total_reg   <= batch_total_next;
            out_valid_reg     <= out_valid_next;
            idx_reg           <= idx_next;
            p_reg             <= p_next;
            cap_reg           <= cap_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        group_index_reg <= group_index_next;
        mask_reg        <= mask_next;
    end

    // per-group counts, cleared at batch start, saturating increment
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < int'(MaxGroups); i++)
                assigned_reg[i] <= '0;
        end
        else if (in_fire && start_batch)
        begin
            for (int i = 0; i < int'(MaxGroups); i++)
                assigned_reg[i] <= '0;
        end
        else if (ctrl.update && (sel_assigned != CountMax))
        begin
            assigned_reg[p_reg] <= sel_assigned + 16'd1;
        end
    end

    // configuration registers; indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg   <= 3'd1;
            group_cpus_reg[0] <= 7'd64;
            group_cpus_reg[1] <= '0;
            group_cpus_reg[2] <= '0;
            group_cpus_reg[3] <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CfgGroupCount: group_count_reg   <= cfg_data[GroupCountW-1:0];
                CfgGroup0Cpus: group_cpus_reg[0] <= cfg_data;
                CfgGroup1Cpus: group_cpus_reg[1] <= cfg_data;
                CfgGroup2Cpus: group_cpus_reg[2] <= cfg_data;
                CfgGroup3Cpus: group_cpus_reg[3] <= cfg_data;
                default:       group_count_reg   <= group_count_reg;
            endcase
        end
    end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for round_robin_group_allocator_unit
// drives worker requests and cpu/group settings, predicts each placement
// (group and affinity mask) and checks every result in order
// ----------------------------------------------------------------------------
module tb;

    import rrga_pkg::*;

    // first index past the cpu count registers, writes there are ignored
    localparam logic [CfgIndexW-1:0] CfgSpareLo = CfgGroup3Cpus + 3'd1;
    localparam int unsigned IdxSpan = 1 << CfgIndexW;
    localparam int unsigned GapMax = 14;
    localparam int unsigned HoldCycles = 300;
    localparam int unsigned DrainCycles = 16;

    typedef struct packed {
        logic [GroupIdxW-1:0] grp;
        logic [MaskW-1:0]     mask;
    } placement_t;

    // clock, reset and block ports
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 start_batch = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [GroupIdxW-1:0] group_index;
    logic [MaskW-1:0]     affinity_mask;
    logic                 cfg_write = 1'b0;
    logic [CfgIndexW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0]  cfg_data = '0;

    // pending requests (start flag only) and placements still to come
    logic       request_q [$];
    placement_t placement_q [$];

    // shadow of the settings and of the allocation state
    logic [GroupCountW-1:0] cfg_groups;
    logic [CpuCountW-1:0]   cfg_cpus [MaxGroups];
    logic [GroupIdxW-1:0]   rr_next;
    logic [CountW-1:0]      placed_cnt [MaxGroups];
    logic [CountW-1:0]      batch_placed;

    // driver and monitor working variables
    logic       drv_busy;
    int         send_gap = 0;
    placement_t drv_exp;
    int         recv_wait = 0;
    int         hold_left = 0;
    placement_t mon_exp;

    // no random gaps on either side while set; the long hold-off still applies
    logic steady = 1'b0;

    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_settings = 0;

    round_robin_group_allocator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .start_batch   (start_batch),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .group_index   (group_index),
        .affinity_mask (affinity_mask),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // cpu count of a group as the allocator sees it, saturated at 64
    function automatic int unsigned cpu_limit(input int unsigned k);
        int unsigned c;
        c = cfg_cpus[k];
        return (c > 64) ? 64 : c;
    endfunction

    // place one worker: advance the shadow state and give group and mask
    function automatic void place_worker(
        input  logic                 start,
        output logic [GroupIdxW-1:0] grp,
        output logic [MaskW-1:0]     mask
    );
        int unsigned g;
        int unsigned cap;
        int unsigned p;
        int unsigned n;
        logic        found;
        g = cfg_groups;
        if (g == 0)
            g = 1;
        if (g > MaxGroups)
            g = MaxGroups;
        // a new batch clears everything before this request
        if (start)
        begin
            for (int k = 0; k < MaxGroups; k++)
                placed_cnt[k] = '0;
            batch_placed = '0;
            rr_next = '0;
        end
        cap = 0;
        for (int k = 0; k < g; k++)
            cap += cpu_limit(k);
        // a stale pointer past the groups in use restarts at group zero
        p = rr_next;
        if (p >= g)
            p = 0;
        // skip full groups unless the batch is oversubscribed
        found = 1'b0;
        for (int k = 0; k < g && !found; k++)
        begin
            if (placed_cnt[p] < cpu_limit(p) || batch_placed >= cap)
                found = 1'b1;
            else
                p = (p + 1) % g;
        end
        if (placed_cnt[p] < CountMax)
            placed_cnt[p] = placed_cnt[p] + 1'b1;
        if (batch_placed < CountMax)
            batch_placed = batch_placed + 1'b1;
        rr_next = GroupIdxW'((p + 1) % g);
        grp = GroupIdxW'(p);
        n = cpu_limit(p);
        if (n == 0)
            mask = '0;
        else if (n >= MaskW)
            mask = '1;
        else
            mask = (64'd1 << n) - 64'd1;
    endfunction

    // request driver: one item at a time, random gap after each acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            start_batch <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            drv_busy = in_valid;
            if (in_valid && !in_stall)
            begin
                // item taken: its placement is now owed
                place_worker(start_batch, drv_exp.grp, drv_exp.mask);
                placement_q.push_back(drv_exp);
                n_sent++;
                drv_busy = 1'b0;
                send_gap = steady ? 0 : $urandom_range(0, GapMax);
            end
            // a stalled item stays as it is
            if (!drv_busy)
            begin
                if (send_gap == 0 && request_q.size() != 0)
                begin
                    in_valid <= 1'b1;
                    start_batch <= request_q.pop_front();
                end
                else
                begin
                    if (send_gap != 0)
                        send_gap--;
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (placement_q.size() == 0)
                begin
                    $display("%0t: result with nothing owed: group %0d mask %h",
                             $time, group_index, affinity_mask);
                    errors++;
                end
                else
                begin
                    mon_exp = placement_q.pop_front();
                    if (group_index !== mon_exp.grp)
                    begin
                        $display("%0t: group_index expected %0d actual %0d",
                                 $time, mon_exp.grp, group_index);
                        errors++;
                    end
                    if (affinity_mask !== mon_exp.mask)
                    begin
                        $display("%0t: affinity_mask expected %h actual %h",
                                 $time, mon_exp.mask, affinity_mask);
                        errors++;
                    end
                end
                n_checked++;
                recv_wait = steady ? 0 : $urandom_range(0, GapMax);
                // now and then a long hold-off so the block backs up
                if (n_checked % 150 == 75)
                    hold_left = HoldCycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // register write while idle, shadow follows
    task automatic write_reg(
        input logic [CfgIndexW-1:0] idx,
        input logic [CfgDataW-1:0]  val
    );
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CfgGroupCount)
            cfg_groups = val[GroupCountW-1:0];
        else if (idx >= CfgGroup0Cpus && idx <= CfgGroup3Cpus)
            cfg_cpus[idx - CfgGroup0Cpus] = val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // all five registers, one after another
    task automatic write_all(
        input logic [CfgDataW-1:0] gc,
        input logic [CfgDataW-1:0] c0,
        input logic [CfgDataW-1:0] c1,
        input logic [CfgDataW-1:0] c2,
        input logic [CfgDataW-1:0] c3
    );
        write_reg(CfgGroupCount, gc);
        write_reg(CfgGroup0Cpus, c0);
        write_reg(CfgGroup1Cpus, c1);
        write_reg(CfgGroup2Cpus, c2);
        write_reg(CfgGroup3Cpus, c3);
        n_settings++;
    endtask

    // wait for every owed result, then let the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        while (request_q.size() != 0 || placement_q.size() != 0 || in_valid)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    // queue a list of start flags given as a bit string, oldest first
    task automatic queue_flags(input int n, input logic [31:0] flags);
        for (int k = n - 1; k >= 0; k--)
            request_q.push_back(flags[k]);
    endtask

    // random batch: mostly opened by a start, the odd restart inside
    task automatic queue_batch(input int n);
        request_q.push_back($urandom_range(0, 3) != 0);
        for (int k = 1; k < n; k++)
            request_q.push_back($urandom_range(0, 15) == 0);
    endtask

    // cpu count: mostly small so batches overrun, sometimes full or oversized
    function automatic logic [CfgDataW-1:0] rand_cpus();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return CfgDataW'($urandom_range(0, 8));
        else if (r < 8)
            return CfgDataW'($urandom_range(0, 64));
        else if (r == 8)
            return CpusMax;
        else
            return CfgDataW'($urandom_range(65, 127));
    endfunction

    function automatic logic [CfgDataW-1:0] rand_groups();
        if ($urandom_range(0, 9) < 8)
            return CfgDataW'($urandom_range(1, MaxGroups));
        return CfgDataW'($urandom_range(0, 7));
    endfunction

    // main sequence
    initial
    begin
        // shadow starts at the reset values
        cfg_groups = 3'd1;
        cfg_cpus[0] = CpusMax;
        for (int k = 1; k < MaxGroups; k++)
            cfg_cpus[k] = '0;
        for (int k = 0; k < MaxGroups; k++)
            placed_cnt[k] = '0;
        rr_next = '0;
        batch_placed = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: one group of 64, no start on the first item
        queue_flags(3, 32'b001);
        wait_idle();

        // four groups, one with no cpus, run past capacity
        write_all(7'd4, 7'd2, 7'd0, 7'd3, 7'd1);
        queue_flags(8, 32'b1000_0000);
        wait_idle();

        // writes past the last register change nothing
        for (int k = CfgSpareLo; k < IdxSpan; k++)
            write_reg(CfgIndexW'(k), CfgDataW'($urandom_range(0, 127)));
        write_reg(CfgSpareLo, 7'h7F);
        queue_flags(2, 32'b00);
        wait_idle();

        // fewer groups mid batch: pointer may sit past the groups in use
        write_reg(CfgGroupCount, 7'd2);
        queue_flags(2, 32'b00);
        wait_idle();

        // zero group count acts as one, oversized cpu count saturates
        write_all(7'd0, 7'h7F, 7'd5, 7'd5, 7'd5);
        queue_flags(2, 32'b10);
        wait_idle();

        // group count above the limit saturates
        write_all(7'd7, CpusMax, CpusMax, 7'd1, 7'd0);
        queue_flags(5, 32'b10000);
        wait_idle();

        // no cpus anywhere: oversubscribed from the first worker
        write_all(7'd4, 7'd0, 7'd0, 7'd0, 7'd0);
        queue_flags(3, 32'b100);
        wait_idle();

        // random phases
        for (int ph = 0; ph < 12; ph++)
        begin
            steady = (ph == 3);
            if (ph == 5)
                write_all(7'd4, CpusMax, CpusMax, CpusMax, CpusMax);
            else if (ph == 8)
                write_all(7'd4, 7'd1, 7'd1, 7'd1, 7'd1);
            else
                write_all(rand_groups(), rand_cpus(), rand_cpus(), rand_cpus(),
                          rand_cpus());
            queue_batch($urandom_range(20, 44));
            wait_idle();
        end
        steady = 1'b0;

        $display("%0d requests under %0d settings, %0d placements checked",
                 n_sent, n_settings, n_checked);
        $display("covered capacity skips, oversubscription, saturation and stalls");
        if (errors == 0 && placement_q.size() == 0)
            $display("** round_robin_group_allocator_unit: PASSED **");
        else
            $display("** round_robin_group_allocator_unit: FAILED **");
        $finish;
    end

    // overall time limit
    initial
    begin
        #400000;
        $display("timeout with %0d placements outstanding", placement_q.size());
        $display("** round_robin_group_allocator_unit: FAILED **");
        $finish;
    end

endmodule

FILE: round_robin_group_allocator_unit.f
rtl/core/rrga_pkg.sv
rtl/core/round_robin_group_allocator_unit.sv
sim/tb.sv
